// ----- design/sbc_pkg.sv -----
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared types, register indexes and defaults of the bar chart span generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbc_pkg;

  localparam int MAX_POINTS_DEF = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int SAMPLE_W   = 8;
  localparam int X_W        = 14;
  localparam int ROW_W      = 8;
  localparam int COLOR_W    = 16;
  localparam int PTS_W      = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_ORIGIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHART_HEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BAR_COLOR     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BAR_WIDTH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_POINTS_IN_USE = 3'd5;

  localparam logic [9:0]         X_ORIGIN_RST      = 10'd0;
  localparam logic [7:0]         Y_ORIGIN_RST      = 8'd0;
  localparam logic [7:0]         CHART_HEIGHT_RST  = 8'd64;
  localparam logic [15:0]        BAR_COLOR_RST     = 16'hFFFF;
  localparam logic [7:0]         BAR_WIDTH_RST     = 8'd1;
  localparam logic [PTS_W-1:0]   POINTS_IN_USE_RST = 6'd32;

  typedef struct packed {
    logic [9:0]       x_origin;
    logic [7:0]       y_origin;
    logic [7:0]       chart_height;
    logic [15:0]      bar_color;
    logic [7:0]       bar_px;
    logic [PTS_W-1:0] points_in_use;
  } cfg_t;

  typedef struct packed {
    logic [X_W-1:0]     x_left;
    logic [X_W-1:0]     x_right;
    logic [ROW_W-1:0]   row_first;
    logic [ROW_W-1:0]   row_end;
    logic [COLOR_W-1:0] span_color;
    logic               last;
  } span_t;

  typedef struct packed {
    logic  a_ok;
    span_t a;
    logic  b_ok;
    span_t b;
  } bar_spans_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_EVAL,
    ST_EMIT_B,
    ST_FLUSH
  } state_t;

endpackage

`default_nettype wire

// ----- design/sbc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// sbc_cfg_regs
// Configuration register file, written through a plain index/data port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbc_cfg_regs
  import sbc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_X_ORIGIN:      cfg_nxt.x_origin      = cfg_wdata[9:0];
        CFG_Y_ORIGIN:      cfg_nxt.y_origin      = cfg_wdata[7:0];
        CFG_CHART_HEIGHT:  cfg_nxt.chart_height  = cfg_wdata[7:0];
        CFG_BAR_COLOR:     cfg_nxt.bar_color     = cfg_wdata[15:0];
        CFG_BAR_WIDTH:     cfg_nxt.bar_px        = cfg_wdata[7:0];
        CFG_POINTS_IN_USE: cfg_nxt.points_in_use = cfg_wdata[PTS_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_origin      <= X_ORIGIN_RST;
      cfg_r.y_origin      <= Y_ORIGIN_RST;
      cfg_r.chart_height  <= CHART_HEIGHT_RST;
      cfg_r.bar_color     <= BAR_COLOR_RST;
      cfg_r.bar_px        <= BAR_WIDTH_RST;
      cfg_r.points_in_use <= POINTS_IN_USE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- design/sbc_store.sv -----
// ----------------------------------------------------------------------------
// sbc_store
// Sample store: one write port, one registered read port, per-entry valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbc_store
  import sbc_pkg::*;
#(
  parameter int DEPTH = MAX_POINTS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                rd_en,
  input  wire logic [AW-1:0]       rd_addr,
  output logic      [SAMPLE_W-1:0] rd_data,
  input  wire logic                wr_en,
  input  wire logic [AW-1:0]       wr_addr,
  input  wire logic [SAMPLE_W-1:0] wr_data
);

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]    valid_r;
  logic [DEPTH-1:0]    valid_nxt;
  logic [SAMPLE_W-1:0] rd_data_r;
  logic                rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (wr_en) begin
      valid_nxt[wr_addr] = 1'b1;
    end
  end

  // entries never written read as the reset value, zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

`default_nettype wire

// ----- design/sbc_span_calc.sv -----
// ----------------------------------------------------------------------------
// sbc_span_calc
// Works out the clear and fill spans of one bar from its old and new values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbc_span_calc
  import sbc_pkg::*;
(
  input  wire cfg_t                       cfg,
  input  wire logic        [X_W-1:0]      x_left,
  input  wire logic signed [SAMPLE_W-1:0] old_val,
  input  wire logic signed [SAMPLE_W-1:0] new_val,
  output bar_spans_t                      spans
);

  logic [ROW_W-1:0] centre;
  logic [ROW_W-1:0] yo;
  logic [ROW_W-1:0] yn;
  logic             old_pos;
  logic             new_pos;
  logic [ROW_W-1:0] a_first;
  logic [ROW_W-1:0] a_end;
  logic [ROW_W-1:0] b_first;
  logic [ROW_W-1:0] b_end;
  logic             a_fill;
  logic             b_used;
  logic [X_W-1:0]   x_right;

  assign centre  = {1'b0, cfg.chart_height[7:1]};
  assign yo      = ROW_W'(cfg.y_origin + $unsigned(old_val) + centre);
  assign yn      = ROW_W'(cfg.y_origin + $unsigned(new_val) + centre);
  assign old_pos = (old_val > 0);
  assign new_pos = (new_val > 0);
  assign x_right = X_W'(x_left + {6'd0, cfg.bar_px});

  always_comb begin
    a_first = yo;
    a_end   = yn;
    a_fill  = 1'b0;
    b_first = centre;
    b_end   = yn;
    b_used  = 1'b0;
    case ({old_pos, new_pos})
      2'b00: begin
        if (old_val < new_val) begin
          a_first = yo;
          a_end   = yn;
        end else begin
          a_first = yn;
          a_end   = yo;
          a_fill  = 1'b1;
        end
      end
      2'b01: begin
        a_first = yo;
        a_end   = centre;
        b_first = centre;
        b_end   = yn;
        b_used  = 1'b1;
      end
      // a new value of zero also clears the positive bar here
      2'b10: begin
        a_first = centre;
        a_end   = yo;
        b_first = yn;
        b_end   = centre;
        b_used  = 1'b1;
      end
      2'b11: begin
        if (old_val > new_val) begin
          a_first = yn;
          a_end   = yo;
        end else begin
          a_first = yo;
          a_end   = yn;
          a_fill  = 1'b1;
        end
      end
      default: begin
        a_first = yo;
        a_end   = yn;
      end
    endcase
  end

  always_comb begin
    spans.a_ok         = (a_first < a_end);
    spans.a.x_left     = x_left;
    spans.a.x_right    = x_right;
    spans.a.row_first  = a_first;
    spans.a.row_end    = a_end;
    spans.a.span_color = a_fill ? cfg.bar_color : '0;
    spans.a.last       = 1'b0;
    spans.b_ok         = b_used && (b_first < b_end);
    spans.b.x_left     = x_left;
    spans.b.x_right    = x_right;
    spans.b.row_first  = b_first;
    spans.b.row_end    = b_end;
    spans.b.span_color = cfg.bar_color;
    spans.b.last       = 1'b0;
  end

endmodule

`default_nettype wire

// ----- design/scrolling_bar_chart_span_gen.sv -----
// Path: a sample passes ST_PRIME and ST_EVAL; the first span comes from the first
// bar that repaints and waits in a pending register before reaching the output.
// Flow: a sample is taken only in ST_IDLE, so the next one waits until the last
// span of this one has moved on; the store read and write-back walk one bar a
// cycle and the output moves one span a cycle unless a stall holds them, and a bar
// giving two spans adds ST_EMIT_B. Reset: synchronous; config defaults return.
// ----------------------------------------------------------------------------
// scrolling_bar_chart_span_gen
// Scrolls samples through a store and emits the spans that repaint each bar.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scrolling_bar_chart_span_gen
  import sbc_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]       cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [SAMPLE_W-1:0]  in_sample,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [X_W-1:0]                   out_x_left,
  output logic [X_W-1:0]                   out_x_right,
  output logic [ROW_W-1:0]                 out_row_first,
  output logic [ROW_W-1:0]                 out_row_end,
  output logic [COLOR_W-1:0]               out_span_color,
  output logic                             out_last
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam logic [PTS_W:0] MAX_PTS = (PTS_W + 1)'(MAX_POINTS);

  cfg_t       cfg;
  bar_spans_t spans;

  state_t state_r, state_nxt;

  logic signed [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic signed [SAMPLE_W-1:0] old_r, old_nxt;
  logic [AW-1:0]              n_r, n_nxt;
  logic [AW-1:0]              nlast_r, nlast_nxt;
  logic [X_W-1:0]             x_left_r, x_left_nxt;
  span_t                      slot_b_r, slot_b_nxt;
  span_t                      pend_r, pend_nxt;
  logic                       pend_valid_r, pend_valid_nxt;
  span_t                      out_r, out_nxt;
  logic                       out_valid_r, out_valid_nxt;

  logic [PTS_W:0]             pts;
  logic [PTS_W:0]             nlim;
  logic [AW:0]                n_plus2;
  logic signed [SAMPLE_W-1:0] new_val;
  logic [SAMPLE_W-1:0]        rd_data;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic                       wr_en;
  logic                       out_free;
  logic                       gen_ok;
  logic                       gen_valid;
  span_t                      gen_span;
  logic                       flush_move;
  logic                       advance;

  sbc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sbc_store #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (n_r),
    .wr_data (new_val)
  );

  sbc_span_calc u_calc (
    .cfg     (cfg),
    .x_left  (x_left_r),
    .old_val (old_r),
    .new_val (new_val),
    .spans   (spans)
  );

  // bars in use, clamped to 1..MAX_POINTS
  assign pts  = {1'b0, cfg.points_in_use};
  assign nlim = (pts == '0) ? (PTS_W + 1)'(1) : ((pts > MAX_PTS) ? MAX_PTS : pts);

  assign n_plus2  = {1'b0, n_r} + (AW + 1)'(2);
  assign new_val  = (n_r == nlast_r) ? sample_r : $signed(rd_data);
  assign out_free = !out_valid_r || out_ready;
  assign gen_ok   = !pend_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    sample_nxt = sample_r;
    old_nxt    = old_r;
    n_nxt      = n_r;
    nlast_nxt  = nlast_r;
    x_left_nxt = x_left_r;
    slot_b_nxt = slot_b_r;
    in_ready   = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    gen_valid  = 1'b0;
    gen_span   = spans.a;
    flush_move = 1'b0;
    advance    = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          sample_nxt = in_sample;
          nlast_nxt  = AW'(nlim - (PTS_W + 1)'(1));
          n_nxt      = '0;
          x_left_nxt = {4'd0, cfg.x_origin};
          rd_en      = 1'b1;
          rd_addr    = '0;
          state_nxt  = ST_PRIME;
        end
      end
      ST_PRIME: begin
        old_nxt = $signed(rd_data);
        if (nlast_r != '0) begin
          rd_en   = 1'b1;
          rd_addr = AW'(1);
        end
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (gen_ok) begin
          wr_en   = 1'b1;
          old_nxt = new_val;
          // fetch the new value of the following bar
          if (n_plus2 <= {1'b0, nlast_r}) begin
            rd_en   = 1'b1;
            rd_addr = n_plus2[AW-1:0];
          end
          if (spans.a_ok) begin
            gen_valid = 1'b1;
            gen_span  = spans.a;
          end else if (spans.b_ok) begin
            gen_valid = 1'b1;
            gen_span  = spans.b;
          end
          if (spans.a_ok && spans.b_ok) begin
            slot_b_nxt = spans.b;
            state_nxt  = ST_EMIT_B;
          end else begin
            advance = 1'b1;
          end
        end
      end
      ST_EMIT_B: begin
        if (gen_ok) begin
          gen_valid = 1'b1;
          gen_span  = slot_b_r;
          advance   = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          flush_move = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (advance) begin
      if (n_r == nlast_r) begin
        state_nxt = ST_FLUSH;
      end else begin
        n_nxt      = n_r + AW'(1);
        x_left_nxt = X_W'(x_left_r + {6'd0, cfg.bar_px});
        state_nxt  = ST_EVAL;
      end
    end
  end

  // one span is held back so the final one of a sample can be marked last
  always_comb begin
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    if (gen_valid) begin
      pend_nxt       = gen_span;
      pend_valid_nxt = 1'b1;
      if (pend_valid_r) begin
        out_nxt       = pend_r;
        out_valid_nxt = 1'b1;
      end
    end else if (flush_move) begin
      pend_valid_nxt = 1'b0;
      out_nxt        = pend_r;
      out_nxt.last   = 1'b1;
      out_valid_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
    old_r    <= old_nxt;
    n_r      <= n_nxt;
    nlast_r  <= nlast_nxt;
    x_left_r <= x_left_nxt;
    slot_b_r <= slot_b_nxt;
    pend_r   <= pend_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_x_left     = out_r.x_left;
  assign out_x_right    = out_r.x_right;
  assign out_row_first  = out_r.row_first;
  assign out_row_end    = out_r.row_end;
  assign out_span_color = out_r.span_color;
  assign out_last       = out_r.last;

endmodule

`default_nettype wire

// ----- design/sbc_checker.sv -----
// ----------------------------------------------------------------------------
// sbc_checker
// Port-level checks of the bar chart span generator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbc_checker
  import sbc_pkg::*;
(
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [X_W-1:0]             out_x_left,
  input wire logic [X_W-1:0]             out_x_right,
  input wire logic [ROW_W-1:0]           out_row_first,
  input wire logic [ROW_W-1:0]           out_row_end,
  input wire logic [COLOR_W-1:0]         out_span_color,
  input wire logic                       out_last
);

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x_left) &&
      $stable(out_x_right) && $stable(out_row_first) && $stable(out_row_end) &&
      $stable(out_span_color) && $stable(out_last))
    else $error("result beat changed while stalled");

  // a sample always keeps the input closed for at least the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a sample");

  // empty spans are never shown
  a_span_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_row_first < out_row_end)
    else $error("empty row range on a span");

  // bar columns never wrap
  a_span_cols: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_x_right >= out_x_left)
    else $error("span right column left of its left column");

endmodule

bind scrolling_bar_chart_span_gen sbc_checker u_sbc_checker (.*);

`default_nettype wire
